>>> hdl/kfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_pkg
// Shared types, key codes and limits for the keypad frequency entry core.
// ----------------------------------------------------------------------------
package kfe_pkg;

    localparam int DEF_MAX_CHARS = 12;
    localparam int DEF_NUM_VFOS  = 2;

    localparam int KEY_W  = 4;
    localparam int LEN_W  = 4;
    localparam int FREQ_W = 60;
    localparam int FRAC_W = 3;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [FREQ_W-1:0] freq_t;
    typedef logic [FRAC_W-1:0] frac_t;

    localparam key_t KEY_POINT = 4'd10;
    localparam key_t KEY_BACK  = 4'd11;
    localparam key_t KEY_CLEAR = 4'd12;
    localparam key_t KEY_HZ    = 4'd13;
    localparam key_t KEY_KHZ   = 4'd14;
    localparam key_t KEY_MHZ   = 4'd15;

    localparam freq_t FREQ_MAX       = 60'd999999999999000000;
    localparam freq_t FREQ_MAX_DIV10 = 60'd99999999999900000;
    localparam freq_t MIN_FREQ       = 60'd10000;

    localparam frac_t SCALE_HZ  = 3'd0;
    localparam frac_t SCALE_KHZ = 3'd3;
    localparam frac_t SCALE_MHZ = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK,
        ST_WALK,
        ST_SCALE,
        ST_FINISH
    } state_t;

    function automatic frac_t scale_of(input key_t key);
        frac_t s;
        case (key)
            KEY_MHZ: s = SCALE_MHZ;
            KEY_KHZ: s = SCALE_KHZ;
            default: s = SCALE_HZ;
        endcase
        return s;
    endfunction

endpackage

>>> hdl/kfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kfe_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/keypad_frequency_entry_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_frequency_entry_core
// Per-tuner keypad entry buffers; enter keys convert the buffer to whole Hz.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata: key, tuser: tuner select
//  m_*     | out | m_tvalid/m_tready  | tdata: hz, length, point; tuser: valid
//
// Digit, point and clear keys go straight to the final state, backspace via
// a read of the dropped character. Enter keys read each stored character,
// then up to six x10 steps or one rounding step on the multiply-by-ten adder.
// Reset empties every buffer at once; character storage needs no clearing.
// s_tready is high only in the idle state; a result waiting on m_tready
// holds the block in its final state until the output register frees.
// ----------------------------------------------------------------------------
module keypad_frequency_entry_core #(
    parameter int MAX_CHARS = kfe_pkg::DEF_MAX_CHARS,
    parameter int NUM_VFOS  = kfe_pkg::DEF_NUM_VFOS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] key, [7:4] zero
    input  logic        s_tuser,   // [0] vfo_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [59:0] frequency_hz, [63:60] entry_length,
                                   // [64] has_point, [71:65] zero
    output logic        m_tuser    // [0] frequency_valid
);

    localparam int DEPTH = NUM_VFOS * MAX_CHARS;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = (NUM_VFOS > 1) ? $clog2(NUM_VFOS) : 1;

    kfe_pkg::state_t state_reg, state_next;

    logic [VW-1:0]      vfo_reg, vfo_next;
    kfe_pkg::frac_t     scale_reg, scale_next;
    logic               enter_reg, enter_next;
    logic               bad_reg, bad_next;
    kfe_pkg::len_t      idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic               after_reg, after_next;
    logic               drop_reg, drop_next;
    logic               rnd_reg, rnd_next;
    kfe_pkg::frac_t     fcnt_reg, fcnt_next;
    kfe_pkg::freq_t     acc_reg, acc_next;

    kfe_pkg::len_t      len_reg [NUM_VFOS];
    kfe_pkg::len_t      len_next [NUM_VFOS];
    logic               point_reg [NUM_VFOS];
    logic               point_next [NUM_VFOS];

    logic               m_tvalid_reg, m_tvalid_next;
    logic               out_valid_reg, out_valid_next;
    kfe_pkg::freq_t     out_hz_reg, out_hz_next;
    kfe_pkg::len_t      out_len_reg, out_len_next;
    logic               out_point_reg, out_point_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    kfe_pkg::key_t      ram_wdata;
    kfe_pkg::key_t      ram_rdata;

    logic               unit_x10;
    kfe_pkg::freq_t     unit_a;
    kfe_pkg::key_t      unit_add;
    kfe_pkg::freq_t     unit_y;

    kfe_pkg::key_t      in_key;
    logic [VW-1:0]      in_idx;
    logic               vfo_ok;
    kfe_pkg::len_t      cur_len;
    logic               cur_point;
    logic [AW-1:0]      base_in;
    logic [AW-1:0]      base_reg;
    kfe_pkg::len_t      len_v;
    logic               accept;
    logic               slot_free;

    assign in_key    = s_tdata[kfe_pkg::KEY_W-1:0];
    assign in_idx    = VW'(s_tuser);
    assign vfo_ok    = (32'(s_tuser) < NUM_VFOS);
    assign cur_len   = vfo_ok ? len_reg[in_idx] : '0;
    assign cur_point = vfo_ok ? point_reg[in_idx] : 1'b0;
    assign base_in   = AW'(32'(in_idx) * MAX_CHARS);
    assign base_reg  = AW'(32'(vfo_reg) * MAX_CHARS);
    assign len_v     = len_reg[vfo_reg];
    assign s_tready  = (state_reg == kfe_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;

    // shared multiply-by-ten and add
    assign unit_y = (unit_x10 ? ((unit_a << 3) + (unit_a << 1)) : unit_a)
                    + kfe_pkg::FREQ_W'(unit_add);

    kfe_ram #(
        .WIDTH (kfe_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_chars (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kfe_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!vfo_ok)
                    begin
                        state_next = kfe_pkg::ST_FINISH;
                    end
                    else if (in_key == kfe_pkg::KEY_BACK && cur_len != '0)
                    begin
                        state_next = kfe_pkg::ST_BACK;
                    end
                    else if (in_key >= kfe_pkg::KEY_HZ)
                    begin
                        state_next = kfe_pkg::ST_WALK;
                    end
                    else
                    begin
                        state_next = kfe_pkg::ST_FINISH;
                    end
                end
            end
            kfe_pkg::ST_BACK:
            begin
                state_next = kfe_pkg::ST_FINISH;
            end
            kfe_pkg::ST_WALK:
            begin
                if (idx_reg == len_v)
                begin
                    state_next = kfe_pkg::ST_SCALE;
                end
            end
            kfe_pkg::ST_SCALE:
            begin
                if (drop_reg || fcnt_reg >= scale_reg)
                begin
                    state_next = kfe_pkg::ST_FINISH;
                end
            end
            kfe_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = kfe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kfe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        vfo_next       = vfo_reg;
        scale_next     = scale_reg;
        enter_next     = enter_reg;
        bad_next       = bad_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        after_next     = after_reg;
        drop_next      = drop_reg;
        rnd_next       = rnd_reg;
        fcnt_next      = fcnt_reg;
        acc_next       = acc_reg;
        len_next       = len_reg;
        point_next     = point_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_valid_next = out_valid_reg;
        out_hz_next    = out_hz_reg;
        out_len_next   = out_len_reg;
        out_point_next = out_point_reg;
        ram_we         = 1'b0;
        ram_waddr      = base_in + AW'(cur_len);
        ram_wdata      = in_key;
        ram_raddr      = base_reg + AW'(idx_reg);
        unit_x10       = 1'b1;
        unit_a         = acc_reg;
        unit_add       = '0;

        case (state_reg)
            kfe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    vfo_next   = in_idx;
                    scale_next = kfe_pkg::scale_of(in_key);
                    enter_next = (in_key >= kfe_pkg::KEY_HZ);
                    bad_next   = !vfo_ok;
                    idx_next   = '0;
                    after_next = 1'b0;
                    drop_next  = 1'b0;
                    rnd_next   = 1'b0;
                    fcnt_next  = '0;
                    acc_next   = '0;
                    if (vfo_ok)
                    begin
                        if (in_key <= kfe_pkg::KEY_POINT)
                        begin
                            if (32'(cur_len) < MAX_CHARS &&
                                !(in_key == kfe_pkg::KEY_POINT && cur_point))
                            begin
                                ram_we           = 1'b1;
                                len_next[in_idx] = cur_len + 1'b1;
                                if (in_key == kfe_pkg::KEY_POINT)
                                begin
                                    point_next[in_idx] = 1'b1;
                                end
                            end
                        end
                        else if (in_key == kfe_pkg::KEY_BACK)
                        begin
                            if (cur_len != '0)
                            begin
                                len_next[in_idx] = cur_len - 1'b1;
                                ram_raddr        = base_in + AW'(cur_len - 1'b1);
                            end
                        end
                        else if (in_key == kfe_pkg::KEY_CLEAR)
                        begin
                            len_next[in_idx]   = '0;
                            point_next[in_idx] = 1'b0;
                        end
                    end
                end
            end
            kfe_pkg::ST_BACK:
            begin
                if (ram_rdata == kfe_pkg::KEY_POINT)
                begin
                    point_next[vfo_reg] = 1'b0;
                end
            end
            kfe_pkg::ST_WALK:
            begin
                if (idx_reg != len_v)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if (ram_rdata > 4'd9)
                    begin
                        after_next = 1'b1;
                    end
                    else if (!after_reg || fcnt_reg < scale_reg)
                    begin
                        unit_add = ram_rdata;
                        acc_next = unit_y;
                        if (after_reg)
                        begin
                            fcnt_next = fcnt_reg + 1'b1;
                        end
                    end
                    else if (!drop_reg)
                    begin
                        // first digit past the scale decides half-up rounding
                        drop_next = 1'b1;
                        rnd_next  = (ram_rdata >= 4'd5);
                    end
                end
            end
            kfe_pkg::ST_SCALE:
            begin
                if (drop_reg)
                begin
                    unit_x10 = 1'b0;
                    unit_add = kfe_pkg::KEY_W'(rnd_reg);
                    acc_next = unit_y;
                end
                else if (fcnt_reg < scale_reg)
                begin
                    if (acc_reg > kfe_pkg::FREQ_MAX_DIV10)
                    begin
                        acc_next  = kfe_pkg::FREQ_MAX;
                        fcnt_next = scale_reg;
                    end
                    else
                    begin
                        acc_next  = unit_y;
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                end
                if (drop_reg || fcnt_reg >= scale_reg)
                begin
                    len_next[vfo_reg]   = '0;
                    point_next[vfo_reg] = 1'b0;
                end
            end
            kfe_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    m_tvalid_next  = 1'b1;
                    out_valid_next = enter_reg && (acc_reg >= kfe_pkg::MIN_FREQ);
                    out_hz_next    = acc_reg;
                    out_len_next   = bad_reg ? '0 : len_v;
                    out_point_next = bad_reg ? 1'b0 : point_reg[vfo_reg];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= kfe_pkg::ST_IDLE;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_VFOS; i++)
            begin
                len_reg[i]   <= '0;
                point_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            len_reg      <= len_next;
            point_reg    <= point_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vfo_reg       <= vfo_next;
        scale_reg     <= scale_next;
        enter_reg     <= enter_next;
        bad_reg       <= bad_next;
        idx_reg       <= idx_next;
        after_reg     <= after_next;
        drop_reg      <= drop_next;
        rnd_reg       <= rnd_next;
        fcnt_reg      <= fcnt_next;
        acc_reg       <= acc_next;
        out_valid_reg <= out_valid_next;
        out_hz_reg    <= out_hz_next;
        out_len_reg   <= out_len_next;
        out_point_reg <= out_point_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_valid_reg;
    assign m_tdata  = {7'd0, out_point_reg, out_len_reg, out_hz_reg};

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[63:60]) <= MAX_CHARS))
        else $error("entry length beyond buffer size");

    a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            (m_tdata[59:0] >= kfe_pkg::MIN_FREQ && m_tdata[59:0] <= kfe_pkg::FREQ_MAX))
        else $error("valid frequency out of range");

    a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == kfe_pkg::ST_WALK))
        else $error("character read pending outside conversion");

endmodule
